[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file smr_checker.sv
// depends on clk and arst_n being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define SMR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define SMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/smr_pkg.sv]
// types, codes and helper functions for the spin magnetisation reduction
// no dependencies
package smr_pkg;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_COL  = 2'd1,
		MODE_NCOL = 2'd2,
		MODE_RSVD = 2'd3
	} spin_mode_t;

	localparam logic [2:0] REG_SPIN_MODE      = 3'd0;
	localparam logic [2:0] REG_CELL_VOLUME    = 3'd1;
	localparam logic [2:0] REG_GRID_TOTAL     = 3'd2;
	localparam logic [2:0] REG_ELECTRON_COUNT = 3'd3;
	localparam logic [2:0] REG_SEPARATE_FERMI = 3'd4;

	localparam int unsigned DIV_STEPS = 96;
	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

	// one point's contribution to the four sums
	typedef struct packed {
		spin_mode_t         mode;
		logic               last;
		logic signed [32:0] add_x;
		logic signed [32:0] add_y;
		logic signed [32:0] add_z;
		logic signed [32:0] add_abs;
	} contrib_t;

	typedef enum logic [2:0] {
		F_IDLE, F_SQ, F_ADD, F_ROOT, F_PUSH
	} f_state_t;

	typedef enum logic [2:0] {
		B_ACC, B_MUL0, B_MUL1, B_DIV, B_STORE, B_DONE
	} b_state_t;

	// 64-bit sum plus 33-bit term, clamped at the 64-bit limits
	function automatic logic signed [63:0] sat_add(logic signed [63:0] s,
			logic signed [32:0] v);
		logic signed [64:0] t;
		t = {s[63], s} + {{32{v[32]}}, v};
		if (t[64] != t[63])
			sat_add = t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			sat_add = t[63:0];
	endfunction

	// capped magnitude with sign restored, clamped to 48 bits
	function automatic logic signed [47:0] to_s48(logic neg, logic [48:0] q);
		if (neg)
			to_s48 = (q >= 49'h0_8000_0000_0000) ? MIN48 : -$signed(q[47:0]);
		else
			to_s48 = (q > 49'h0_7FFF_FFFF_FFFF) ? MAX48 : $signed(q[47:0]);
	endfunction

endpackage

[hw/rtl/smr_if.sv]
// point and result channel interfaces
// depends on nothing
interface smr_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] density_a;
	logic signed [31:0] density_b;
	logic signed [31:0] density_c;
	logic signed [31:0] density_d;
	logic               last_point;
	modport source (output valid, density_a, density_b, density_c, density_d, last_point,
		input ready);
	modport sink (input valid, density_a, density_b, density_c, density_d, last_point,
		output ready);
endinterface

interface smr_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] total_mag_x;
	logic signed [47:0] total_mag_y;
	logic signed [47:0] total_mag_z;
	logic        [46:0] absolute_mag;
	logic signed [47:0] electrons_up;
	logic signed [47:0] electrons_down;
	logic               electrons_valid;
	modport source (output valid, total_mag_x, total_mag_y, total_mag_z, absolute_mag,
		electrons_up, electrons_down, electrons_valid, input ready);
	modport sink (input valid, total_mag_x, total_mag_y, total_mag_z, absolute_mag,
		electrons_up, electrons_down, electrons_valid, output ready);
endinterface

[hw/rtl/smr_front.sv]
// front end: takes point beats, forms each point's contribution
// depends on smr_pkg and smr_if; square root runs two bits per cycle
module smr_front import smr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  spin_mode_t  spin_mode,
	smr_point_if.sink   points,
	input  logic        q_full,
	output logic        q_push,
	output contrib_t    q_data
);

	f_state_t state_q, state_d;
	contrib_t ent_q;
	logic signed [31:0] b_q, c_q, d_q;
	logic [63:0] sqb_s1, sqc_s1, sqd_s1;
	logic [63:0] x_q, r_q, bit_q;
	logic [4:0]  step_q;
	logic        accept;
	logic signed [32:0] diff;
	logic [64:0] trial;

	assign points.ready = (state_q == F_IDLE);
	assign accept = points.valid && points.ready;
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign diff = {points.density_a[31], points.density_a}
		- {points.density_b[31], points.density_b};
	assign trial = {1'b0, r_q} + {1'b0, bit_q};

	// entry to the queue, root patched in for noncollinear points
	always_comb begin
		q_data = ent_q;
		if (ent_q.mode == MODE_NCOL)
			q_data.add_abs = {1'b0, r_q[31:0]};
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept)
					state_d = (spin_mode == MODE_NCOL) ? F_SQ : F_PUSH;
			end
			F_SQ:   state_d = F_ADD;
			F_ADD:  state_d = F_ROOT;
			F_ROOT: begin
				if (step_q == 5'd31)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q.mode <= spin_mode;
			ent_q.last <= points.last_point;
			b_q <= points.density_b;
			c_q <= points.density_c;
			d_q <= points.density_d;
			case (spin_mode)
				MODE_COL: begin
					ent_q.add_x   <= diff;
					ent_q.add_y   <= '0;
					ent_q.add_z   <= '0;
					ent_q.add_abs <= diff[32] ? -diff : diff;
				end
				MODE_NCOL: begin
					ent_q.add_x   <= {points.density_b[31], points.density_b};
					ent_q.add_y   <= {points.density_c[31], points.density_c};
					ent_q.add_z   <= {points.density_d[31], points.density_d};
					ent_q.add_abs <= '0;
				end
				default: begin
					ent_q.add_x   <= '0;
					ent_q.add_y   <= '0;
					ent_q.add_z   <= '0;
					ent_q.add_abs <= '0;
				end
			endcase
		end
		if (state_q == F_SQ) begin
			sqb_s1 <= b_q * b_q;
			sqc_s1 <= c_q * c_q;
			sqd_s1 <= d_q * d_q;
		end
		if (state_q == F_ADD) begin
			x_q    <= sqb_s1 + sqc_s1 + sqd_s1;
			r_q    <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
			step_q <= '0;
		end
		// one digit of the integer square root
		if (state_q == F_ROOT) begin
			if ({1'b0, x_q} >= trial) begin
				x_q <= x_q - trial[63:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q  <= bit_q >> 2;
			step_q <= step_q + 5'd1;
		end
	end

endmodule

[hw/rtl/smr_queue.sv]
// two-entry queue between front and back
// depends on smr_pkg
module smr_queue import smr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  contrib_t wdata,
	input  logic     pop,
	output contrib_t rdata,
	output logic     full,
	output logic     empty
);

	contrib_t   mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

[hw/rtl/smr_back.sv]
// back end: saturating sums, end-of-pass scaling and the result register
// depends on smr_pkg and smr_if; one shared restoring divider, one bit per cycle
module smr_back import smr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [31:0]  cell_volume,
	input  logic [30:0]  grid_total,
	input  logic [31:0]  electron_count,
	input  logic         separate_fermi,
	input  logic         q_empty,
	input  contrib_t     q_data,
	output logic         q_pop,
	smr_result_if.source results
);

	b_state_t state_q, state_d;
	logic signed [63:0] sx_q, sy_q, sz_q, sa_q;
	logic signed [63:0] nx, ny, nz, na;
	logic signed [63:0] snap_q [4];
	logic [48:0] qres_q [4];
	spin_mode_t mode_q;
	logic [1:0]  k_q;
	logic [63:0] mag;
	logic [63:0] plo_s1;
	logic [95:0] prod_q;
	logic [46:0] rem_q, dvs;
	logic [47:0] rem2;
	logic [48:0] quo_q;
	logic        ovf_q;
	logic [6:0]  cnt_q;
	logic        res_v_q, load;
	logic signed [47:0] mx, my, mz, eu, ed;
	logic [46:0] ma;
	logic        ev;
	logic signed [49:0] ne, vu, vd;

	assign q_pop = (state_q == B_ACC) && !q_empty;
	assign load  = (state_q == B_DONE) && (!res_v_q || results.ready);
	assign results.valid = res_v_q;
	assign dvs  = (grid_total == 31'd0) ? 47'h1_0000 : {grid_total, 16'd0};
	assign mag  = snap_q[k_q][63] ? 64'd0 - snap_q[k_q] : snap_q[k_q];
	assign rem2 = {rem_q, prod_q[95]};

	// next sums
	always_comb begin
		nx = sat_add(sx_q, q_data.add_x);
		ny = sat_add(sy_q, q_data.add_y);
		nz = sat_add(sz_q, q_data.add_z);
		na = sat_add(sa_q, q_data.add_abs);
		if (q_data.mode != MODE_COL && q_data.mode != MODE_NCOL) begin
			nx = sx_q;
			ny = sy_q;
			nz = sz_q;
			na = sa_q;
		end
	end

	// final fields from the four capped quotients
	always_comb begin
		mx = to_s48(snap_q[0][63], qres_q[0]);
		my = to_s48(snap_q[1][63], qres_q[1]);
		mz = to_s48(snap_q[2][63], qres_q[2]);
		ma = (qres_q[3] > 49'h0_7FFF_FFFF_FFFF) ? {47{1'b1}} : qres_q[3][46:0];
		ev = (mode_q == MODE_COL) && !separate_fermi;
		ne = {10'd0, electron_count, 8'd0};
		vu = ne + {{2{mx[47]}}, mx};
		vd = ne - {{2{mx[47]}}, mx};
		eu = '0;
		ed = '0;
		if (ev) begin
			eu = 48'((vu + {49'd0, vu[49]}) >>> 1);
			ed = 48'((vd + {49'd0, vd[49]}) >>> 1);
		end
		if (mode_q == MODE_COL) begin
			my = '0;
			mz = '0;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_ACC;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_ACC: begin
				if (q_pop && q_data.last
						&& (q_data.mode == MODE_COL || q_data.mode == MODE_NCOL))
					state_d = B_MUL0;
			end
			B_MUL0: state_d = B_MUL1;
			B_MUL1: state_d = B_DIV;
			B_DIV: begin
				if (cnt_q == 7'(DIV_STEPS - 1))
					state_d = B_STORE;
			end
			B_STORE: state_d = (k_q == 2'd3) ? B_DONE : B_MUL0;
			B_DONE: begin
				if (load)
					state_d = B_ACC;
			end
			default: state_d = B_ACC;
		endcase
	end

	// sums and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q    <= '0;
			sy_q    <= '0;
			sz_q    <= '0;
			sa_q    <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_data.last) begin
					sx_q <= '0;
					sy_q <= '0;
					sz_q <= '0;
					sa_q <= '0;
				end else begin
					sx_q <= nx;
					sy_q <= ny;
					sz_q <= nz;
					sa_q <= na;
				end
			end
			if (load)
				res_v_q <= 1'b1;
			else if (results.ready)
				res_v_q <= 1'b0;
		end
	end

	// scaling datapath
	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			snap_q[0] <= nx;
			snap_q[1] <= ny;
			snap_q[2] <= nz;
			snap_q[3] <= na;
			mode_q    <= q_data.mode;
			k_q       <= 2'd0;
		end
		if (state_q == B_MUL0)
			plo_s1 <= mag[31:0] * cell_volume;
		if (state_q == B_MUL1) begin
			prod_q <= {32'd0, plo_s1} + {64'(mag[63:32]) * 64'(cell_volume), 32'd0};
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end
		// one quotient bit, sticky once past the cap
		if (state_q == B_DIV) begin
			prod_q <= prod_q << 1;
			cnt_q  <= cnt_q + 7'd1;
			ovf_q  <= ovf_q | quo_q[48];
			if (rem2 >= {1'b0, dvs}) begin
				rem_q <= 47'(rem2 - {1'b0, dvs});
				quo_q <= {quo_q[47:0], 1'b1};
			end else begin
				rem_q <= rem2[46:0];
				quo_q <= {quo_q[47:0], 1'b0};
			end
		end
		if (state_q == B_STORE) begin
			qres_q[k_q] <= (ovf_q || quo_q[48]) ? 49'h1_0000_0000_0000 : quo_q;
			k_q <= k_q + 2'd1;
		end
		if (load) begin
			results.total_mag_x     <= mx;
			results.total_mag_y     <= my;
			results.total_mag_z     <= mz;
			results.absolute_mag    <= ma;
			results.electrons_up    <= eu;
			results.electrons_down  <= ed;
			results.electrons_valid <= ev;
		end
	end

endmodule

[hw/rtl/spin_magnetization_reduce.sv]
// spin magnetisation reduction, top level
// depends on smr_pkg, smr_if, smr_front, smr_queue, smr_back
//
// channel   dir  beat contents
// points    in   density_a..d (Q8.24), last_point
// results   out  total_mag_x/y/z (Q24.24), absolute_mag (Q23.24), electron split
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// a collinear or idle-mode point goes from idle straight to push in the front end,
// a noncollinear point first through three squares and a 32-step square root.
// the back end adds one queued point per cycle while accumulating; the last point
// scales four sums (two multiply, 96 divide, one store) and loads the result.
// reset sets config to defaults and clears sums and queue at once; no clearing pass.
// front keeps taking points while a result waits in the output register, until the queue is full.
module spin_magnetization_reduce import smr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	smr_point_if.sink     points,
	smr_result_if.source  results
);

	spin_mode_t  spin_mode_q;
	logic [31:0] cell_volume_q;
	logic [30:0] grid_total_q;
	logic [31:0] electron_count_q;
	logic        separate_fermi_q;
	logic        q_push, q_pop, q_full, q_empty;
	contrib_t    q_wdata, q_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_mode_q      <= MODE_NONE;
			cell_volume_q    <= 32'h0001_0000;
			grid_total_q     <= 31'd1;
			electron_count_q <= '0;
			separate_fermi_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPIN_MODE:      spin_mode_q      <= spin_mode_t'(cfg_data[1:0]);
				REG_CELL_VOLUME:    cell_volume_q    <= cfg_data;
				REG_GRID_TOTAL:     grid_total_q     <= cfg_data[30:0];
				REG_ELECTRON_COUNT: electron_count_q <= cfg_data;
				REG_SEPARATE_FERMI: separate_fermi_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	smr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.spin_mode (spin_mode_q),
		.points    (points),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	smr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	smr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cell_volume    (cell_volume_q),
		.grid_total     (grid_total_q),
		.electron_count (electron_count_q),
		.separate_fermi (separate_fermi_q),
		.q_empty        (q_empty),
		.q_data         (q_rdata),
		.q_pop          (q_pop),
		.results        (results)
	);

endmodule

[hw/rtl/smr_checker.sv]
// port-level checks on the result channel, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module smr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [47:0] mag_y,
	input logic signed [47:0] mag_z,
	input logic signed [47:0] el_up,
	input logic signed [47:0] el_down,
	input logic               el_valid
);

	// a waiting result beat is not withdrawn
	`SMR_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid, "result beat dropped")
	// electron split only in collinear mode, where y and z are zero
	`SMR_ASSERT_NOW(a_col_yz, res_valid && el_valid, mag_y == 48'sd0 && mag_z == 48'sd0,
		"y or z non-zero with electron split")
	// no split means zero electron fields
	`SMR_ASSERT_NOW(a_no_split, res_valid && !el_valid, el_up == 48'sd0 && el_down == 48'sd0,
		"electron fields set without split")

endmodule

bind spin_magnetization_reduce smr_checker u_smr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.mag_y     (results.total_mag_y),
	.mag_z     (results.total_mag_z),
	.el_up     (results.electrons_up),
	.el_down   (results.electrons_down),
	.el_valid  (results.electrons_valid)
);
